// File: sv/mtis_pkg.sv
package mtis_pkg;

   localparam int MAX_THREADS = 8;
   localparam int TID_W       = $clog2(MAX_THREADS);
   localparam int TCNT_W      = TID_W + 1;
   localparam int PC_W        = 32;
   localparam int CNT_W       = 32;
   localparam int WAIT_W      = 8;
   localparam int KIND_W      = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 8;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 112;

   typedef logic [TID_W-1:0]       tid_type;
   typedef logic [TCNT_W-1:0]      tcnt_type;
   typedef logic [MAX_THREADS-1:0] thread_mask_type;
   typedef logic [WAIT_W-1:0]      wait_type;
   typedef logic [PC_W-1:0]        pc_type;
   typedef logic [CNT_W-1:0]       cnt_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALU   = 2'd0,
      KIND_LOAD  = 2'd1,
      KIND_STORE = 2'd2,
      KIND_HALT  = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE           = 3'd0,
      CSR_THREAD_COUNT   = 3'd1,
      CSR_LOAD_WAIT      = 3'd2,
      CSR_STORE_WAIT     = 3'd3,
      CSR_SWITCH_PENALTY = 3'd4
   } csr_index_type;

   localparam logic MODE_FINE    = 1'b0;
   localparam logic MODE_BLOCKED = 1'b1;

   typedef struct packed {
      logic     en;
      logic     issue;
      tid_type  thread;
      kind_type kind;
      wait_type load_wait;
      wait_type store_wait;
   } thread_ctrl_type;

   typedef struct packed {
      thread_mask_type halted_pre;
      thread_mask_type idle_pre;
      thread_mask_type halted_post;
      thread_mask_type idle_post;
   } thread_stat_type;

   typedef struct packed {
      logic    issued;
      tid_type issued_thread;
      tid_type next_thread;
      pc_type  next_pc;
      logic    switched;
      logic    all_done;
      cnt_type cycles;
      cnt_type instructions;
   } rsp_type;

endpackage

// File: sv/mtis_rr_pick.sv
module mtis_rr_pick (
   input  mtis_pkg::tid_type         from,
   input  mtis_pkg::thread_mask_type ready,
   input  mtis_pkg::tcnt_type        count,
   output mtis_pkg::tid_type         pick
);

   mtis_pkg::tcnt_type cand [mtis_pkg::MAX_THREADS];
   logic [mtis_pkg::MAX_THREADS-1:0] hit;

   always_comb begin
      for (int k = 0; k < mtis_pkg::MAX_THREADS; k++) begin
         cand[k] = {1'b0, from} + mtis_pkg::TCNT_W'(k);
         if (cand[k] >= count) begin
            cand[k] = cand[k] - count;
         end
         hit[k] = (k != 0) && (mtis_pkg::TCNT_W'(k) < count)
                  && ready[cand[k][mtis_pkg::TID_W-1:0]];
      end
   end

   // first ready thread after the current one, else stay
   always_comb begin
      pick = from;
      for (int k = mtis_pkg::MAX_THREADS - 1; k > 0; k--) begin
         if (hit[k]) begin
            pick = cand[k][mtis_pkg::TID_W-1:0];
         end
      end
   end

endmodule

// File: sv/mtis_thread_regs.sv
module mtis_thread_regs (
   input  logic                      clock,
   input  logic                      reset,
   input  mtis_pkg::thread_ctrl_type ctrl,
   input  mtis_pkg::tid_type         rd_thread,
   output mtis_pkg::pc_type          rd_pc,
   output mtis_pkg::thread_stat_type stat
);

   logic               halted_ff [mtis_pkg::MAX_THREADS];
   logic               halted_in [mtis_pkg::MAX_THREADS];
   mtis_pkg::pc_type   pc_ff     [mtis_pkg::MAX_THREADS];
   mtis_pkg::pc_type   pc_in     [mtis_pkg::MAX_THREADS];
   mtis_pkg::wait_type lc_ff     [mtis_pkg::MAX_THREADS];
   mtis_pkg::wait_type lc_in     [mtis_pkg::MAX_THREADS];
   mtis_pkg::wait_type sc_ff     [mtis_pkg::MAX_THREADS];
   mtis_pkg::wait_type sc_in     [mtis_pkg::MAX_THREADS];
   logic               sel       [mtis_pkg::MAX_THREADS];

   always_comb begin
      for (int t = 0; t < mtis_pkg::MAX_THREADS; t++) begin
         sel[t] = ctrl.issue && (ctrl.thread == mtis_pkg::TID_W'(t));
         lc_in[t] = (lc_ff[t] != '0) ? lc_ff[t] - mtis_pkg::WAIT_W'(1) : lc_ff[t];
         sc_in[t] = (sc_ff[t] != '0) ? sc_ff[t] - mtis_pkg::WAIT_W'(1) : sc_ff[t];
         halted_in[t] = halted_ff[t];
         pc_in[t] = pc_ff[t];
         if (sel[t]) begin
            pc_in[t] = pc_ff[t] + mtis_pkg::PC_W'(1);
            case (ctrl.kind)
               mtis_pkg::KIND_LOAD:  lc_in[t] = ctrl.load_wait;
               mtis_pkg::KIND_STORE: sc_in[t] = ctrl.store_wait;
               mtis_pkg::KIND_HALT:  halted_in[t] = 1'b1;
               default:              ;
            endcase
         end
         stat.halted_pre[t]  = halted_ff[t];
         stat.idle_pre[t]    = (lc_ff[t] == '0) && (sc_ff[t] == '0);
         stat.halted_post[t] = halted_in[t];
         stat.idle_post[t]   = (lc_in[t] == '0) && (sc_in[t] == '0);
      end
   end

   assign rd_pc = pc_in[rd_thread];

   always_ff @(posedge clock) begin
      for (int t = 0; t < mtis_pkg::MAX_THREADS; t++) begin
         if (reset) begin
            halted_ff[t] <= 1'b0;
            pc_ff[t]     <= '0;
            lc_ff[t]     <= '0;
            sc_ff[t]     <= '0;
         end else if (ctrl.en) begin
            halted_ff[t] <= halted_in[t];
            pc_ff[t]     <= pc_in[t];
            lc_ff[t]     <= lc_in[t];
            sc_ff[t]     <= sc_in[t];
         end
      end
   end

endmodule

// File: sv/multithread_issue_scheduler_core.sv
// Thread issue scheduler: one req item per clock tick, carrying the kind of the
// instruction fetched for the current thread; one rsp item per tick with the
// issue outcome, the thread and pc to fetch next and the running counters.
// Throughput is one item per cycle while rsp_tready keeps up. An accepted req
// goes into an input register, then in a single pass through the thread-state
// update and round-robin pick into the result register that drives rsp_tvalid.
// The whole tick is resolved in that one pass, since the next tick depends on
// the updated thread state. One extra item is taken while a result waits on
// rsp_tready.
// Configuration writes are accepted at any time but belong between runs.
module multithread_issue_scheduler_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [1:0] instr_kind
   input  logic [mtis_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] issued, [3:1] issued_thread, [6:4] next_thread, [38:7] next_pc,
   // [39] switched, [40] all_done, [72:41] cycles, [104:73] instructions
   output logic [mtis_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mtis_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mtis_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic               mode_ff;
   mtis_pkg::tcnt_type thread_count_ff;
   mtis_pkg::wait_type load_wait_ff;
   mtis_pkg::wait_type store_wait_ff;
   mtis_pkg::wait_type switch_penalty_ff;

   logic               in_valid_ff;
   mtis_pkg::kind_type kind_ff;
   logic               out_valid_ff;
   mtis_pkg::rsp_type  res_ff;
   mtis_pkg::rsp_type  res_in;

   mtis_pkg::tid_type  cur_ff;
   mtis_pkg::tid_type  cur_in;
   mtis_pkg::wait_type penalty_ff;
   mtis_pkg::wait_type penalty_in;
   mtis_pkg::cnt_type  cycle_ff;
   mtis_pkg::cnt_type  cycle_in;
   mtis_pkg::cnt_type  issue_cnt_ff;
   mtis_pkg::cnt_type  issue_cnt_in;

   logic                      advance;
   logic                      upd;
   logic                      state_en;
   mtis_pkg::tcnt_type        n_eff;
   mtis_pkg::thread_mask_type active;
   mtis_pkg::tid_type         ct0;
   logic                      done_pre;
   logic                      done_post;
   mtis_pkg::thread_mask_type ready_pre;
   mtis_pkg::thread_mask_type ready_post;
   logic                      do_issue;
   mtis_pkg::wait_type        pen_after;
   mtis_pkg::tid_type         pick;
   mtis_pkg::tid_type         nt;
   logic                      do_switch;
   mtis_pkg::pc_type          next_pc;
   mtis_pkg::thread_ctrl_type ctrl;
   mtis_pkg::thread_stat_type stat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= mtis_pkg::MODE_FINE;
         thread_count_ff   <= mtis_pkg::TCNT_W'(mtis_pkg::MAX_THREADS);
         load_wait_ff      <= mtis_pkg::WAIT_W'(4);
         store_wait_ff     <= mtis_pkg::WAIT_W'(1);
         switch_penalty_ff <= mtis_pkg::WAIT_W'(2);
      end else if (csr_valid) begin
         unique case (csr_index)
            mtis_pkg::CSR_MODE:           mode_ff <= csr_data[0];
            mtis_pkg::CSR_THREAD_COUNT:   thread_count_ff <= csr_data[mtis_pkg::TCNT_W-1:0];
            mtis_pkg::CSR_LOAD_WAIT:      load_wait_ff <= csr_data;
            mtis_pkg::CSR_STORE_WAIT:     store_wait_ff <= csr_data;
            mtis_pkg::CSR_SWITCH_PENALTY: switch_penalty_ff <= csr_data;
            default:                      ;
         endcase
      end
   end

   assign advance    = !out_valid_ff || rsp_tready;
   assign upd        = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (req_tvalid && req_tready) begin
         kind_ff <= mtis_pkg::kind_type'(req_tdata[mtis_pkg::KIND_W-1:0]);
      end
   end

   // thread count: 0 acts as 1, above the maximum as the maximum
   always_comb begin
      if (thread_count_ff == '0) begin
         n_eff = mtis_pkg::TCNT_W'(1);
      end else if (thread_count_ff > mtis_pkg::TCNT_W'(mtis_pkg::MAX_THREADS)) begin
         n_eff = mtis_pkg::TCNT_W'(mtis_pkg::MAX_THREADS);
      end else begin
         n_eff = thread_count_ff;
      end
      for (int t = 0; t < mtis_pkg::MAX_THREADS; t++) begin
         active[t] = mtis_pkg::TCNT_W'(t) < n_eff;
      end
   end

   assign ct0        = ({1'b0, cur_ff} >= n_eff) ? '0 : cur_ff;
   assign ready_pre  = active & ~stat.halted_pre & stat.idle_pre;
   assign ready_post = active & ~stat.halted_post & stat.idle_post;
   assign done_pre   = &(stat.halted_pre | ~active);
   assign done_post  = &(stat.halted_post | ~active);
   assign do_issue   = !done_pre && (penalty_ff == '0) && ready_pre[ct0];
   assign state_en   = upd && !done_pre;
   assign pen_after  = (penalty_ff != '0) ? penalty_ff - mtis_pkg::WAIT_W'(1) : penalty_ff;

   always_comb begin
      ctrl.en         = state_en;
      ctrl.issue      = do_issue;
      ctrl.thread     = ct0;
      ctrl.kind       = kind_ff;
      ctrl.load_wait  = load_wait_ff;
      ctrl.store_wait = store_wait_ff;
   end

   mtis_thread_regs u_thread_regs (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .rd_thread (nt),
      .rd_pc     (next_pc),
      .stat      (stat)
   );

   mtis_rr_pick u_rr_pick (
      .from  (ct0),
      .ready (ready_post),
      .count (n_eff),
      .pick  (pick)
   );

   always_comb begin
      nt         = ct0;
      do_switch  = 1'b0;
      penalty_in = penalty_ff;
      if (!done_pre) begin
         penalty_in = pen_after;
         if (!done_post && pen_after == '0) begin
            if (mode_ff == mtis_pkg::MODE_FINE) begin
               nt = pick;
            end else if (!ready_post[ct0] && pick != ct0) begin
               nt         = pick;
               penalty_in = switch_penalty_ff;
               do_switch  = 1'b1;
            end
         end
      end
   end

   assign cur_in       = nt;
   assign cycle_in     = done_pre ? cycle_ff : cycle_ff + mtis_pkg::CNT_W'(1);
   assign issue_cnt_in = do_issue ? issue_cnt_ff + mtis_pkg::CNT_W'(1) : issue_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         penalty_ff   <= '0;
         cycle_ff     <= '0;
         issue_cnt_ff <= '0;
      end else if (upd) begin
         cur_ff       <= cur_in;
         penalty_ff   <= penalty_in;
         cycle_ff     <= cycle_in;
         issue_cnt_ff <= issue_cnt_in;
      end
   end

   always_comb begin
      res_in.issued        = do_issue;
      res_in.issued_thread = ct0;
      res_in.next_thread   = nt;
      res_in.next_pc       = next_pc;
      res_in.switched      = do_switch;
      res_in.all_done      = done_post;
      res_in.cycles        = cycle_in;
      res_in.instructions  = issue_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (upd) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (upd) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, res_ff.instructions, res_ff.cycles, res_ff.all_done,
                        res_ff.switched, res_ff.next_pc, res_ff.next_thread,
                        res_ff.issued_thread, res_ff.issued};

`ifndef SYNTHESIS
   a_issue_count : assert property (@(posedge clock) disable iff (reset)
      (upd && do_issue) |=> issue_cnt_ff == $past(issue_cnt_ff) + mtis_pkg::CNT_W'(1))
      else $error("issue counter did not advance on issue");

   a_switch_moves : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && res_ff.switched) |-> res_ff.next_thread != res_ff.issued_thread)
      else $error("switch reported without a thread change");

   a_stall_only_full : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("input stalled with room in the pipeline");
`endif

endmodule
